/* sv/binomial_coefficient_unit_defines.svh */
// Assertion helpers shared by the binomial coefficient unit.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef BINOMIAL_COEFFICIENT_UNIT_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define BCU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("binomial coefficient unit: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define BCU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("binomial coefficient unit: next-cycle check failed");

`endif

/* sv/bcu_pkg.sv */
`timescale 1ns / 1ps

package bcu_pkg;

    // Width of the accumulated coefficient.
    localparam int ACC_W = 64;
    // Width of one stored divisor and of the divide unit's divisor.
    localparam int DIV_W = 7;
    // Width of the input arguments n and k.
    localparam int ARG_W = 8;

    // Command to the shared divide unit.
    typedef struct packed {
        logic start;
        logic wide;   // 1: full 64-bit dividend, 0: 7-bit dividend
    } div_ctrl_t;

    // Status from the shared divide unit.
    typedef struct packed {
        logic busy;
        logic done;   // one-cycle pulse once quotient and remainder are valid
    } div_stat_t;

endpackage

/* sv/bcu_divider.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. A wide operation divides the
// full 64-bit dividend; a narrow one divides a 7-bit dividend. The divisor is
// 7 bits and is never zero when the unit is started.
module bcu_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bcu_pkg::div_ctrl_t           ctrl,
    input  logic [bcu_pkg::ACC_W-1:0]    dividend,
    input  logic [bcu_pkg::DIV_W-1:0]    divisor,
    output bcu_pkg::div_stat_t           stat,
    output logic [bcu_pkg::ACC_W-1:0]    quotient,
    output logic [bcu_pkg::DIV_W-1:0]    remainder
);

    localparam int CNT_W = $clog2(bcu_pkg::ACC_W + 1);
    localparam int PAD_W = bcu_pkg::ACC_W - bcu_pkg::DIV_W;

    logic [bcu_pkg::ACC_W-1:0] q_reg;
    logic [bcu_pkg::DIV_W-1:0] r_reg;
    logic [bcu_pkg::DIV_W-1:0] dv_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [bcu_pkg::DIV_W:0]   trial;
    logic [bcu_pkg::DIV_W:0]   trial_diff;
    logic                      trial_ge;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        trial      = {r_reg, q_reg[bcu_pkg::ACC_W-1]};
        trial_ge   = trial >= {1'b0, dv_reg};
        trial_diff = trial - {1'b0, dv_reg};
    end

    // Control: busy while bits remain, done pulses after the last bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: a narrow dividend is left-aligned so the same shifter serves.
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            q_reg   <= ctrl.wide ? dividend
                                 : {dividend[bcu_pkg::DIV_W-1:0], {PAD_W{1'b0}}};
            r_reg   <= '0;
            dv_reg  <= divisor;
            cnt_reg <= ctrl.wide ? CNT_W'(bcu_pkg::ACC_W) : CNT_W'(bcu_pkg::DIV_W);
        end else if (busy_reg) begin
            q_reg   <= {q_reg[bcu_pkg::ACC_W-2:0], trial_ge};
            r_reg   <= trial_ge ? trial_diff[bcu_pkg::DIV_W-1:0]
                                : trial[bcu_pkg::DIV_W-1:0];
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

/* sv/binomial_coefficient_unit.sv */
`timescale 1ns / 1ps

// Binomial coefficient unit: takes n and k and returns n choose k as a 64-bit
// value, or zero with the error flag when k exceeds n, when the reduced k
// exceeds MAX_K, or when a partial product would pass 2^64-1. One item is
// worked at a time; s_tready is high only while the unit is idle. Trivial
// cases go straight to the finishing step and return to idle once the output
// register is free. Otherwise k = min(k, n-k) and the time is set by the
// single shared bit-serial divider and the divisor store's one read port:
// a fill pass, then for each of k factors a multiply and a walk over the k
// stored divisors. A divisor equal to one is skipped. For a larger one a wide
// division gives the accumulator's remainder, a narrow division per Euclid
// step finds the GCD and, when a common factor is found, the accumulator and
// then the divisor are divided by it. A last sweep divides the accumulator by
// each divisor left above one, and a finishing step hands the result to the
// output register. The result waits there while the next item is taken.
`include "binomial_coefficient_unit_defines.svh"

module binomial_coefficient_unit #(
    parameter int MAX_K = 127
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] n_value, [15:8] k_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] coefficient
    output logic [0:0]  m_tuser    // [0] error_flag
);

    localparam int ACC_W = bcu_pkg::ACC_W;
    localparam int DIV_W = bcu_pkg::DIV_W;
    localparam int ARG_W = bcu_pkg::ARG_W;
    localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int PRD_W = ACC_W + ARG_W;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_FILL      = 4'd1;
    localparam logic [3:0] ST_MUL       = 4'd2;
    localparam logic [3:0] ST_SLOT_RD   = 4'd3;
    localparam logic [3:0] ST_SLOT_CHK  = 4'd4;
    localparam logic [3:0] ST_MOD_WAIT  = 4'd5;
    localparam logic [3:0] ST_GCD       = 4'd6;
    localparam logic [3:0] ST_GCD_WAIT  = 4'd7;
    localparam logic [3:0] ST_DIVA_WAIT = 4'd8;
    localparam logic [3:0] ST_DIVD_WAIT = 4'd9;
    localparam logic [3:0] ST_NEXT_SLOT = 4'd10;
    localparam logic [3:0] ST_FIN_RD    = 4'd11;
    localparam logic [3:0] ST_FIN_CHK   = 4'd12;
    localparam logic [3:0] ST_FIN_WAIT  = 4'd13;
    localparam logic [3:0] ST_FIN_NEXT  = 4'd14;
    localparam logic [3:0] ST_FINISH    = 4'd15;

    logic [3:0]       state_reg,  state_next;
    logic [ARG_W-1:0] n_reg,      n_next;
    logic [ARG_W-1:0] k_reg,      k_next;
    logic [ARG_W-1:0] factor_reg, factor_next;
    logic [IDX_W-1:0] slot_reg,   slot_next;
    logic [ACC_W-1:0] acc_reg,    acc_next;
    logic             err_reg,    err_next;
    logic [DIV_W-1:0] d_reg,      d_next;
    logic [DIV_W-1:0] ga_reg,     ga_next;
    logic [DIV_W-1:0] gb_reg,     gb_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [ACC_W-1:0] m_tdata_reg,  m_tdata_next;
    logic             m_tuser_reg,  m_tuser_next;

    // Divisor store with a registered read port.
    logic [DIV_W-1:0] store_mem [MAX_K];
    logic [DIV_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [DIV_W-1:0] mem_wdata;

    // Shared divide unit.
    bcu_pkg::div_ctrl_t div_ctrl;
    bcu_pkg::div_stat_t div_stat;
    logic [ACC_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic [ACC_W-1:0]   div_quot;
    logic [DIV_W-1:0]   div_rem;

    // Input decode.
    logic [ARG_W-1:0] n_in;
    logic [ARG_W-1:0] k_in;
    logic [ARG_W-1:0] nk_diff;
    logic [ARG_W-1:0] k_red;
    logic [PRD_W-1:0] product;
    logic             s_accept;
    logic             out_free;
    logic             last_slot_fill;

    bcu_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign n_in     = s_tdata[7:0];
    assign k_in     = s_tdata[15:8];
    assign nk_diff  = n_in - k_in;
    assign k_red    = (nk_diff < k_in) ? nk_diff : k_in;
    assign product  = PRD_W'(acc_reg) * PRD_W'(factor_reg);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign last_slot_fill = (slot_reg == IDX_W'(k_reg - ARG_W'(1)));

    // Sequencer and datapath next-state logic.
    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        factor_next   = factor_reg;
        slot_next     = slot_reg;
        acc_next      = acc_reg;
        err_next      = err_reg;
        d_next        = d_reg;
        ga_next       = ga_reg;
        gb_next       = gb_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mem_we        = 1'b0;
        mem_wdata     = '0;
        div_ctrl      = '0;
        div_dividend  = acc_reg;
        div_divisor   = d_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    n_next      = n_in;
                    k_next      = k_red;
                    slot_next   = '0;
                    acc_next    = ACC_W'(1);
                    err_next    = 1'b0;
                    factor_next = n_in - k_red + ARG_W'(1);
                    if (k_in > n_in) begin
                        acc_next   = '0;
                        err_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else if (n_in == '0 || k_red == '0) begin
                        state_next = ST_FINISH;
                    end else if (k_red > ARG_W'(MAX_K)) begin
                        acc_next   = '0;
                        err_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_FILL;
                    end
                end
            end

            // Load the store with 1..k.
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = DIV_W'(slot_reg) + DIV_W'(1);
                if (last_slot_fill) begin
                    state_next = ST_MUL;
                end else begin
                    slot_next = slot_reg + IDX_W'(1);
                end
            end

            // Multiply by the next factor; a carry past 64 bits is overflow.
            ST_MUL: begin
                if (product[PRD_W-1:ACC_W] != '0) begin
                    acc_next   = '0;
                    err_next   = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    acc_next   = product[ACC_W-1:0];
                    slot_next  = IDX_W'(k_reg - ARG_W'(1));
                    state_next = ST_SLOT_RD;
                end
            end

            ST_SLOT_RD: begin
                state_next = ST_SLOT_CHK;
            end

            // A divisor of one shares no factor; otherwise start acc mod d.
            ST_SLOT_CHK: begin
                d_next = rd_data_reg;
                if (rd_data_reg <= DIV_W'(1)) begin
                    state_next = ST_NEXT_SLOT;
                end else begin
                    div_ctrl.start = 1'b1;
                    div_ctrl.wide  = 1'b1;
                    div_divisor    = rd_data_reg;
                    state_next     = ST_MOD_WAIT;
                end
            end

            ST_MOD_WAIT: begin
                if (div_stat.done) begin
                    ga_next    = d_reg;
                    gb_next    = div_rem;
                    state_next = ST_GCD;
                end
            end

            // Euclid loop on the narrow pair; when it ends ga holds the GCD.
            ST_GCD: begin
                if (gb_reg == '0) begin
                    if (ga_reg == DIV_W'(1)) begin
                        state_next = ST_NEXT_SLOT;
                    end else begin
                        div_ctrl.start = 1'b1;
                        div_ctrl.wide  = 1'b1;
                        div_divisor    = ga_reg;
                        state_next     = ST_DIVA_WAIT;
                    end
                end else begin
                    div_ctrl.start = 1'b1;
                    div_ctrl.wide  = 1'b0;
                    div_dividend   = ACC_W'(ga_reg);
                    div_divisor    = gb_reg;
                    state_next     = ST_GCD_WAIT;
                end
            end

            ST_GCD_WAIT: begin
                if (div_stat.done) begin
                    ga_next    = gb_reg;
                    gb_next    = div_rem;
                    state_next = ST_GCD;
                end
            end

            // Divide the accumulator by the GCD, then the divisor.
            ST_DIVA_WAIT: begin
                if (div_stat.done) begin
                    acc_next       = div_quot;
                    div_ctrl.start = 1'b1;
                    div_ctrl.wide  = 1'b0;
                    div_dividend   = ACC_W'(d_reg);
                    div_divisor    = ga_reg;
                    state_next     = ST_DIVD_WAIT;
                end
            end

            ST_DIVD_WAIT: begin
                if (div_stat.done) begin
                    mem_we     = 1'b1;
                    mem_wdata  = div_quot[DIV_W-1:0];
                    state_next = ST_NEXT_SLOT;
                end
            end

            // Walk the slots downward; after slot zero take the next factor.
            ST_NEXT_SLOT: begin
                if (slot_reg == '0) begin
                    if (factor_reg == n_reg) begin
                        slot_next  = IDX_W'(k_reg - ARG_W'(1));
                        state_next = ST_FIN_RD;
                    end else begin
                        factor_next = factor_reg + ARG_W'(1);
                        state_next  = ST_MUL;
                    end
                end else begin
                    slot_next  = slot_reg - IDX_W'(1);
                    state_next = ST_SLOT_RD;
                end
            end

            ST_FIN_RD: begin
                state_next = ST_FIN_CHK;
            end

            // Divide out any divisor that is still above one.
            ST_FIN_CHK: begin
                if (rd_data_reg <= DIV_W'(1)) begin
                    state_next = ST_FIN_NEXT;
                end else begin
                    div_ctrl.start = 1'b1;
                    div_ctrl.wide  = 1'b1;
                    div_divisor    = rd_data_reg;
                    state_next     = ST_FIN_WAIT;
                end
            end

            ST_FIN_WAIT: begin
                if (div_stat.done) begin
                    acc_next   = div_quot;
                    state_next = ST_FIN_NEXT;
                end
            end

            ST_FIN_NEXT: begin
                if (slot_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    slot_next  = slot_reg - IDX_W'(1);
                    state_next = ST_FIN_RD;
                end
            end

            // Hand the result to the output register once it is free.
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = acc_reg;
                    m_tuser_next  = err_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        k_reg       <= k_next;
        factor_reg  <= factor_next;
        slot_reg    <= slot_next;
        acc_reg     <= acc_next;
        err_reg     <= err_next;
        d_reg       <= d_next;
        ga_reg      <= ga_next;
        gb_reg      <= gb_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // Divisor store: one write and one registered read at the current slot.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[slot_reg] <= mem_wdata;
        end
        rd_data_reg <= store_mem[slot_reg];
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // An item is presented only by the finishing step of the sequencer.
    `BCU_ASSERT_IMPL(a_out_from_finish, $rose(m_tvalid_reg), $past(state_reg) == ST_FINISH)
    // An error result always carries a zero coefficient.
    `BCU_ASSERT_IMPL(a_err_zero, m_tvalid_reg && m_tuser_reg, m_tdata_reg == '0)
    // The divider is never restarted while it is still working.
    `BCU_ASSERT_IMPL(a_div_idle_start, div_ctrl.start, !div_stat.busy)
    // The fill pass stays inside the reduced k.
    `BCU_ASSERT_IMPL(a_fill_range, state_reg == ST_FILL, ARG_W'(slot_reg) < k_reg)
    // A start always sets the divider's busy flag.
    `BCU_ASSERT_NEXT(a_div_wait, div_ctrl.start, div_stat.busy)

endmodule
